@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent property checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)

`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

@@ rtl/bdda_pkg.sv @@
// ----------------------------------------------------------------------------
// bdda_pkg
// Types, codes and calendar helpers for the business-day date adder.
// ----------------------------------------------------------------------------
package bdda_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [13:0] MAX_YEAR = 14'd9999;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_DATE = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [2:0] WD_SUNDAY   = 3'd0;
  localparam logic [2:0] WD_FRIDAY   = 3'd5;
  localparam logic [2:0] WD_SATURDAY = 3'd6;

  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [11:0] business_days;
  } bdda_req_t;

  typedef struct packed {
    logic [4:0]  end_day;
    logic [3:0]  end_month;
    logic [13:0] end_year;
    logic [2:0]  end_weekday;
    logic [1:0]  status;
  } bdda_rsp_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
    logic [11:0] days_left;
    logic [6:0]  year_mod100;
    logic [1:0]  cent_mod4;
    logic        bad_date;
  } bdda_item_t;

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2: len = leap ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // (31 * shifted month) / 12, March counted as month one
  function automatic logic [4:0] month_offset(input logic [3:0] m);
    logic [4:0] off;
    case (m)
      4'd1:  off = 5'd28;
      4'd2:  off = 5'd31;
      4'd3:  off = 5'd2;
      4'd4:  off = 5'd5;
      4'd5:  off = 5'd7;
      4'd6:  off = 5'd10;
      4'd7:  off = 5'd12;
      4'd8:  off = 5'd15;
      4'd9:  off = 5'd18;
      4'd10: off = 5'd20;
      4'd11: off = 5'd23;
      4'd12: off = 5'd25;
      default: off = 5'd0;
    endcase
    return off;
  endfunction

  function automatic logic is_weekend(input logic [2:0] wd);
    return (wd == WD_FRIDAY) || (wd == WD_SATURDAY);
  endfunction

endpackage

@@ rtl/bdda_front.sv @@
// ----------------------------------------------------------------------------
// bdda_front
// Accept requests, check the start date and work out its weekday.
// ----------------------------------------------------------------------------
module bdda_front import bdda_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  bdda_req_t  req,
  output logic       push_valid,
  input  logic       push_ready,
  output bdda_item_t push_data
);

  localparam logic [12:0] RECIP_100 = 13'd5243;

  logic        adv;

  logic        s1_valid;
  bdda_req_t   s1_req;

  logic        s2_valid;
  bdda_req_t   s2_req;
  logic [13:0] s2_yy;
  logic [26:0] s2_y_prod;
  logic [26:0] s2_yy_prod;
  logic [4:0]  s2_moff;

  logic        s3_valid;
  bdda_req_t   s3_req;
  logic        s3_ok;
  logic [6:0]  s3_ymod;
  logic [1:0]  s3_c4;
  logic [15:0] s3_wsum;

  logic [13:0] s1_yy;
  logic [7:0]  y100;
  logic [7:0]  yy100;
  logic [14:0] y_rem;
  logic        leap;
  logic [4:0]  mlen;
  logic        date_ok;
  logic [15:0] wsum;
  logic [5:0]  fold1;
  logic [3:0]  fold2;
  logic [2:0]  wd;

  assign adv       = !s3_valid || push_ready;
  assign req_ready = adv;

  assign s1_yy = (s1_req.start_month <= 4'd2) ? s1_req.start_year - 14'd1
                                              : s1_req.start_year;

  assign y100  = s2_y_prod[26:19];
  assign yy100 = s2_yy_prod[26:19];
  assign y_rem = {1'b0, s2_req.start_year} - 15'(y100 * 8'd100);
  assign leap  = (s2_req.start_year[1:0] == 2'd0) &&
                 ((y_rem[6:0] != 7'd0) || (y100[1:0] == 2'd0));
  assign mlen  = month_len(leap, s2_req.start_month);
  assign date_ok = (s2_req.start_year != 14'd0) && (s2_req.start_year <= MAX_YEAR) &&
                   (s2_req.start_month != 4'd0) && (s2_req.start_month <= MONTH_DEC) &&
                   (s2_req.start_day != 5'd0) && (s2_req.start_day <= mlen);
  assign wsum  = 16'(s2_req.start_day) + 16'(s2_yy) + 16'(s2_yy[13:2])
               - 16'(yy100) + 16'(yy100[7:2]) + 16'(s2_moff);

  assign fold1 = 6'(s3_wsum[2:0]) + 6'(s3_wsum[5:3]) + 6'(s3_wsum[8:6])
               + 6'(s3_wsum[11:9]) + 6'(s3_wsum[14:12]) + 6'(s3_wsum[15]);
  assign fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
  assign wd    = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

  always_comb begin
    push_valid            = s3_valid;
    push_data.day         = s3_req.start_day;
    push_data.month       = s3_req.start_month;
    push_data.year        = s3_req.start_year;
    push_data.weekday     = s3_ok ? wd : WD_SUNDAY;
    push_data.days_left   = s3_req.business_days;
    push_data.year_mod100 = s3_ymod;
    push_data.cent_mod4   = s3_c4;
    push_data.bad_date    = !s3_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= req_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req     <= req;
      s2_req     <= s1_req;
      s2_yy      <= s1_yy;
      s2_y_prod  <= 27'(s1_req.start_year * RECIP_100);
      s2_yy_prod <= 27'(s1_yy * RECIP_100);
      s2_moff    <= month_offset(s1_req.start_month);
      s3_req     <= s2_req;
      s3_ok      <= date_ok;
      s3_ymod    <= y_rem[6:0];
      s3_c4      <= y100[1:0];
      s3_wsum    <= wsum;
    end
  end

endmodule

@@ rtl/bdda_queue.sv @@
// ----------------------------------------------------------------------------
// bdda_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdda_queue import bdda_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  bdda_item_t push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output bdda_item_t pop_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bdda_item_t    slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `ASSERT_NEVER(a_count_bound, clk, rst, count > CW'(DEPTH), "queue count above depth")
  `ASSERT_PROP(a_count_up, clk, rst, (push && !pop) |=> (count == $past(count) + 1'b1), "queue count missed a push")
  `ASSERT_PROP(a_count_down, clk, rst, (pop && !push) |=> (count == $past(count) - 1'b1), "queue count missed a pop")

endmodule

@@ rtl/bdda_back.sv @@
// ----------------------------------------------------------------------------
// bdda_back
// Walk the calendar one day a cycle and hold the result for transfer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdda_back import bdda_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  bdda_item_t pop_data,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output bdda_rsp_t  rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_WALK,
    ST_TAIL,
    ST_FINISH
  } state_t;

  state_t      state;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [13:0] year;
  logic [2:0]  wd;
  logic [11:0] left;
  logic [6:0]  ymod;
  logic [1:0]  c4;
  logic [1:0]  status;

  logic        leap;
  logic [4:0]  mlen;
  logic        eom;
  logic        step_ovf;
  logic [4:0]  day_next;
  logic [3:0]  month_next;
  logic [13:0] year_next;
  logic [6:0]  ymod_next;
  logic [1:0]  c4_next;
  logic [2:0]  wd_next;
  logic        wknd;
  logic        rsp_free;

  assign pop_ready = (state == ST_IDLE);
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign wknd      = is_weekend(wd);

  always_comb begin
    leap       = (year[1:0] == 2'd0) && ((ymod != 7'd0) || (c4 == 2'd0));
    mlen       = month_len(leap, month);
    eom        = (day >= mlen);
    step_ovf   = eom && (month >= MONTH_DEC) && (year >= MAX_YEAR);
    day_next   = eom ? 5'd1 : day + 5'd1;
    month_next = month;
    year_next  = year;
    ymod_next  = ymod;
    c4_next    = c4;
    if (eom) begin
      if (month >= MONTH_DEC) begin
        month_next = 4'd1;
        year_next  = year + 14'd1;
        ymod_next  = (ymod == 7'd99) ? 7'd0 : ymod + 7'd1;
        c4_next    = (ymod == 7'd99) ? c4 + 2'd1 : c4;
      end else begin
        month_next = month + 4'd1;
      end
    end
    wd_next = (wd == WD_SATURDAY) ? WD_SUNDAY : wd + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == ST_FINISH) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            day   <= pop_data.day;
            month <= pop_data.month;
            year  <= pop_data.year;
            wd    <= pop_data.weekday;
            left  <= pop_data.days_left;
            ymod  <= pop_data.year_mod100;
            c4    <= pop_data.cent_mod4;
            if (pop_data.bad_date) begin
              status <= STATUS_BAD_DATE;
              state  <= ST_FINISH;
            end else begin
              status <= STATUS_OK;
              state  <= ST_HEAD;
            end
          end
        end
        ST_HEAD, ST_WALK, ST_TAIL: begin
          if ((state == ST_WALK) && (left == 12'd0)) begin
            state <= ST_TAIL;
          end else if ((state != ST_WALK) && !wknd) begin
            state <= (state == ST_HEAD) ? ST_WALK : ST_FINISH;
          end else if (step_ovf) begin
            status <= STATUS_OVERFLOW;
            state  <= ST_FINISH;
          end else begin
            if ((state == ST_WALK) && !wknd) begin
              left <= left - 12'd1;
            end
            day   <= day_next;
            month <= month_next;
            year  <= year_next;
            ymod  <= ymod_next;
            c4    <= c4_next;
            wd    <= wd_next;
          end
        end
        ST_FINISH: begin
          if (rsp_free) begin
            rsp.end_day     <= day;
            rsp.end_month   <= month;
            rsp.end_year    <= year;
            rsp.end_weekday <= wd;
            rsp.status      <= status;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_PROP(a_rsp_from_finish, clk, rst, $rose(rsp_valid) |-> $past(state == ST_FINISH), "result raised outside finish")
  `ASSERT_PROP(a_walk_date_sane, clk, rst, ((state == ST_HEAD) || (state == ST_WALK) || (state == ST_TAIL)) |-> ((day != 5'd0) && (month != 4'd0) && (month <= MONTH_DEC) && (wd <= WD_SATURDAY)), "walk date out of range")
  `ASSERT_PROP(a_left_falls, clk, rst, ((state == ST_WALK) && $past(state == ST_WALK)) |-> (left <= $past(left)), "business day count rose")
  `ASSERT_PROP(a_ovf_at_limit, clk, rst, ((state == ST_FINISH) && (status == STATUS_OVERFLOW)) |-> ((day == 5'd31) && (month == MONTH_DEC) && (year == MAX_YEAR)), "overflow away from last date")

endmodule

@@ rtl/business_day_date_adder.sv @@
// ----------------------------------------------------------------------------
// business_day_date_adder
// Adds a count of business days (Friday and Saturday off) to a calendar date.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_valid / req_ready  bdda_req_t: start date, business days
//  rsp      out  rsp_valid / rsp_ready  bdda_rsp_t: return date, weekday, status
//
//  The front takes a request every cycle unless a full queue stalls it, into a
//  three-stage check and weekday pipeline; the back then steps one calendar day
//  per cycle. The back works one request at a time and sets the sustained rate.
//  Reset clears control state only; no memory needs a clearing pass.
//  A stalled result holds in the output register while the back starts the next.
// ----------------------------------------------------------------------------
module business_day_date_adder import bdda_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  bdda_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output bdda_rsp_t rsp
);

  logic       push_valid;
  logic       push_ready;
  bdda_item_t push_data;
  logic       pop_valid;
  logic       pop_ready;
  bdda_item_t pop_data;

  bdda_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bdda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bdda_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

@@ tb/tb_business_day_date_adder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_business_day_date_adder
// Sends start dates with business-day counts into the adder and checks every
// returned date, weekday and status against a calendar walk computed here,
// in transfer order. Directed cases cover field extremes, bad dates, leap
// years, weekend starts and running past the last year. Random traffic then
// follows, with bursts of idling on both channels and a clean stretch at the end.
// ----------------------------------------------------------------------------
module tb_business_day_date_adder;
  import bdda_pkg::*;

  localparam int unsigned QUIET_LIMIT = 30000;
  localparam int unsigned SETTLE_CYCLES = 20;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  bdda_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  bdda_rsp_t rsp;

  bit          idle_en = 1'b1;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rsp_hold = 0;
  bdda_rsp_t   return_date_q[$];

  business_day_date_adder dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned days_in_month(int unsigned yr, int unsigned mon);
    bit leap;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    case (mon)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11: return 30;
      2: return leap ? 29 : 28;
      default: return 0;
    endcase
  endfunction

  function automatic bdda_rsp_t predict_return_date(bdda_req_t r);
    int unsigned day;
    int unsigned mon;
    int unsigned yr;
    int unsigned wd;
    int unsigned left;
    int unsigned shift;
    int unsigned ys;
    int unsigned ms;
    logic [1:0]  st;
    bit          off_day;
    bdda_rsp_t   res;
    day = 32'(r.start_day);
    mon = 32'(r.start_month);
    yr = 32'(r.start_year);
    left = 32'(r.business_days);
    wd = 32'(WD_SUNDAY);
    st = STATUS_OK;
    if (yr < 1 || yr > 32'(MAX_YEAR) || mon < 1 || mon > 32'(MONTH_DEC) || day < 1 ||
        day > days_in_month(yr, mon)) begin
      st = STATUS_BAD_DATE;
    end else begin
      shift = (14 - mon) / 12;
      ys = yr - shift;
      ms = mon + 12 * shift - 2;
      wd = (day + ys + ys / 4 - ys / 100 + ys / 400 + (31 * ms) / 12) % 7;
      // skip leading weekend, count business days, skip trailing weekend
      off_day = (wd == 32'(WD_FRIDAY)) || (wd == 32'(WD_SATURDAY));
      while (st == STATUS_OK && (off_day || left != 0)) begin
        if (!off_day) begin
          left--;
        end
        if (day >= days_in_month(yr, mon)) begin
          if (mon >= 32'(MONTH_DEC)) begin
            if (yr >= 32'(MAX_YEAR)) begin
              st = STATUS_OVERFLOW;
            end else begin
              day = 1;
              mon = 1;
              yr++;
            end
          end else begin
            day = 1;
            mon++;
          end
        end else begin
          day++;
        end
        if (st == STATUS_OK) begin
          wd = (wd + 1) % 7;
        end
        off_day = (wd == 32'(WD_FRIDAY)) || (wd == 32'(WD_SATURDAY));
      end
    end
    res.end_day = day[4:0];
    res.end_month = mon[3:0];
    res.end_year = yr[13:0];
    res.end_weekday = wd[2:0];
    res.status = st;
    return res;
  endfunction

  function automatic bdda_req_t make_request(int unsigned d, int unsigned m,
                                             int unsigned y, int unsigned n);
    bdda_req_t r;
    r.start_day = d[4:0];
    r.start_month = m[3:0];
    r.start_year = y[13:0];
    r.business_days = n[11:0];
    return r;
  endfunction

  function automatic bdda_req_t random_request();
    bdda_req_t   r;
    int unsigned pick;
    pick = $urandom_range(0, 19);
    r.start_year = (pick < 3) ? 14'($urandom_range(9975, 9999))
                              : 14'($urandom_range(1, 9999));
    r.start_month = 4'($urandom_range(1, 12));
    if (pick >= 3 && pick < 6) begin
      r.start_day = 5'(days_in_month(32'(r.start_year), 32'(r.start_month)));
    end else if (pick == 16) begin
      r.start_day = 5'($urandom_range(29, 31));
    end else begin
      r.start_day = 5'($urandom_range(1, days_in_month(32'(r.start_year),
                                                       32'(r.start_month))));
    end
    r.business_days = (pick == 19) ? 12'($urandom_range(1000, 4095))
                                   : 12'($urandom_range(0, 40));
    if (pick == 17 || pick == 18) begin
      r.start_day = 5'($urandom_range(0, 31));
      r.start_month = 4'($urandom_range(0, 15));
      r.start_year = 14'($urandom_range(0, 16383));
      r.business_days = 12'($urandom_range(0, 60));
    end
    return r;
  endfunction

  task automatic send_request(input bdda_req_t item);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    return_date_q.push_back(predict_return_date(item));
  endtask

  // hold the sender until every outstanding return date is back
  task automatic drain_results;
    req_valid <= 1'b0;
    @(posedge clk);
    while (return_date_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_field_extremes;
    send_request(make_request(1, 1, 1, 0));
    send_request(make_request(1, 1, 1, 4095));
    send_request(make_request(31, 12, 1, 1));
    send_request(make_request(31, 1, 2024, 4095));
    send_request(make_request(1, 12, 9998, 4095));
    send_request(make_request(31, 12, 9999, 0));
    drain_results();
  endtask

  task automatic test_invalid_dates;
    send_request(make_request(0, 0, 0, 0));
    send_request(make_request(31, 15, 16383, 4095));
    send_request(make_request(1, 1, 10000, 5));
    send_request(make_request(15, 0, 2020, 3));
    send_request(make_request(15, 13, 2020, 3));
    send_request(make_request(0, 6, 2020, 3));
    send_request(make_request(31, 4, 2021, 2));
    send_request(make_request(29, 2, 1900, 1));
    send_request(make_request(30, 2, 2000, 1));
    drain_results();
  endtask

  task automatic test_month_and_leap_edges;
    send_request(make_request(29, 2, 2000, 1));
    send_request(make_request(28, 2, 2100, 1));
    send_request(make_request(29, 2, 2024, 3));
    send_request(make_request(31, 12, 1999, 5));
    drain_results();
  endtask

  task automatic test_weekend_starts;
    send_request(make_request(5, 1, 2024, 0));
    send_request(make_request(6, 1, 2024, 0));
    send_request(make_request(7, 1, 2024, 0));
    send_request(make_request(5, 1, 2024, 1));
    drain_results();
  endtask

  task automatic test_year_overflow;
    send_request(make_request(30, 12, 9999, 0));
    send_request(make_request(30, 12, 9999, 1));
    send_request(make_request(24, 12, 9999, 5));
    drain_results();
  endtask

  task automatic test_random_traffic(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_request(random_request());
    end
    drain_results();
  endtask

  task automatic test_back_to_back(input int unsigned count);
    idle_en = 1'b0;
    for (int unsigned i = 0; i < count; i++) begin
      send_request(random_request());
    end
    drain_results();
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_hold = 0;
    end else if (rsp_hold != 0) begin
      rsp_hold--;
      rsp_ready <= (rsp_hold == 0);
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      rsp_hold = $urandom_range(1, 8);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_transfer
    bdda_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (return_date_q.size() == 0) begin
        $error("unexpected result transfer: %p", rsp);
        fail_count++;
      end else begin
        want = return_date_q.pop_front();
        compare_field("end_day", 32'(want.end_day), 32'(rsp.end_day));
        compare_field("end_month", 32'(want.end_month), 32'(rsp.end_month));
        compare_field("end_year", 32'(want.end_year), 32'(rsp.end_year));
        compare_field("end_weekday", 32'(want.end_weekday), 32'(rsp.end_weekday));
        compare_field("status", 32'(want.status), 32'(rsp.status));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_invalid_dates();
    test_month_and_leap_edges();
    test_weekend_starts();
    test_year_overflow();
    test_random_traffic(55);
    test_back_to_back(20);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
